[rtl/i2cbs_pkg.sv]
// Package for the I2C master bit sequencer: command and status codes, the
// one-hot sequence states, register map constants and the word structs.
// Used by every module of the block; depends on nothing.
`default_nettype none

package i2cbs_pkg;

    // Width of the configuration data bus and of the byte address.
    localparam int unsigned DataW = 32;
    localparam int unsigned AddrW = 3;

    // Register indexes.
    localparam logic [AddrW-3:0] REG_DELAY = '0;

    // Reset value of the phase length.
    localparam logic [7:0] DELAY_RESET = 8'd10;

    // Command codes carried by each input word.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_RECOVER = 3'd5;

    // Completion status codes.
    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_START_FAIL = 2'd1;
    localparam logic [1:0] STS_NACK       = 2'd2;

    // Number of data bits in one byte transfer.
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_STOP   = 7'b0000100,
        S_WRITE  = 7'b0001000,
        S_READ   = 7'b0010000,
        S_RPULSE = 7'b0100000,
        S_RSTOP  = 7'b1000000
    } t_seq_state;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

endpackage

`default_nettype wire

[rtl/i2c_master_bit_sequencer_top.sv]
// Top level of the I2C master bit sequencer: input and result registers,
// handshake control, and instances of i2cbs_apb and i2cbs_engine.
// Depends on i2cbs_pkg and both submodules.
//
// Usage. Every input word is one bus tick: it carries the sampled SDA level
// and, while the sequencer is idle, may carry a command (start, stop, write
// byte, read byte, bus recovery). Each accepted word yields exactly one
// result word with the SCL and SDA drive levels, busy and done flags, the
// status of the last finished command, the last read byte, and a flag that
// marks a command that came while busy and was dropped.
// Both channels use valid/ready. An accepted word is held in an input
// register; once the result register can take a result, the engine updates
// its state from that word and the result lands in the output register.
// One word is taken every cycle while results drain.
// When the receiver stalls, the result register holds, the input register
// fills, and ready drops until the receiver takes the waiting result.
// Reset (synchronous, active low) empties both registers, returns the engine
// to idle with both lines released, and sets the phase length to 10 ticks.
// The phase length register sits at byte address 0 of the APB-style port
// and should be written only while the sequencer is idle.
`default_nettype none

module i2c_master_bit_sequencer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [2:0]                  i_cmd,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_send_ack,
    input  wire logic                        i_sda_sample,
    // Result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_scl_level,
    output logic                             o_sda_level,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic      [1:0]                  o_status,
    output logic      [7:0]                  o_read_byte,
    output logic                             o_rejected,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cbs_pkg::AddrW-1:0] paddr,
    input  wire logic [i2cbs_pkg::DataW-1:0] pwdata,
    output logic      [i2cbs_pkg::DataW-1:0] prdata,
    output logic                             pready
);
    import i2cbs_pkg::*;

    logic       r_in_vld, n_in_vld;
    t_item      r_in;
    logic       r_out_vld, n_out_vld;
    t_result    r_out;
    t_result    step_res;
    logic       out_free;
    logic       step_en;
    logic       in_take;
    logic [7:0] delay_ticks;

    i2cbs_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_delay_ticks (delay_ticks)
    );

    // The engine advances only when a word sits in the input register and
    // the result register can take its result.
    assign out_free   = !r_out_vld || i_out_ready;
    assign step_en    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || step_en;
    assign in_take    = i_in_valid && o_in_ready;

    i2cbs_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (step_en),
        .i_item        (r_in),
        .i_delay_ticks (delay_ticks),
        .o_res         (step_res)
    );

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (step_en) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (step_en) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers carry no reset; their valid bits gate them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd        <= i_cmd;
            r_in.data_byte  <= i_data_byte;
            r_in.send_ack   <= i_send_ack;
            r_in.sda_sample <= i_sda_sample;
        end
        if (step_en) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_scl_level = r_out.scl_level;
    assign o_sda_level = r_out.sda_level;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_status    = r_out.status;
    assign o_read_byte = r_out.read_byte;
    assign o_rejected  = r_out.rejected;

endmodule

`default_nettype wire

[rtl/i2cbs_apb.sv]
// Configuration register file of the I2C master bit sequencer (phase length).
// APB-style slave with zero wait states; depends on i2cbs_pkg.
`default_nettype none

module i2cbs_apb (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cbs_pkg::AddrW-1:0] paddr,
    input  wire logic [i2cbs_pkg::DataW-1:0] pwdata,
    output logic      [i2cbs_pkg::DataW-1:0] prdata,
    output logic                             pready,
    output logic      [7:0]                  o_delay_ticks
);
    import i2cbs_pkg::*;

    logic [7:0]       r_delay;
    logic [7:0]       n_delay;
    logic [AddrW-3:0] reg_idx;
    logic             wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrW-1:2];
    assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_DELAY);

    always_comb begin
        n_delay = r_delay;
        if (wr_hit) begin
            n_delay = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else begin
            r_delay <= n_delay;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_DELAY) begin
            prdata = {{(DataW-8){1'b0}}, r_delay};
        end
    end

    assign o_delay_ticks = r_delay;

endmodule

`default_nettype wire

[rtl/i2cbs_engine.sv]
// Sequencing engine of the I2C master bit sequencer: the bus state registers
// and the next-state logic that handles one input word per enabled cycle.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire i2cbs_pkg::t_item   i_item,
    input  wire logic [7:0]         i_delay_ticks,
    output i2cbs_pkg::t_result      o_res
);
    import i2cbs_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] shift;
    } t_lines;

    // Line levels driven on entry to a phase.
    function automatic t_lines phase_lines(
        input t_seq_state st,
        input logic [1:0] ph,
        input logic [3:0] bits,
        input logic [7:0] shift,
        input logic       ack,
        input logic       scl,
        input logic       sda
    );
        t_lines l;
        l = '{scl: scl, sda: sda, shift: shift};
        case (st)
            S_START: begin
                if (ph == 2'd0) begin
                    l.scl = 1'b1;
                    l.sda = 1'b1;
                end else begin
                    l.sda = 1'b0;
                end
            end
            S_STOP, S_RSTOP: begin
                case (ph)
                    2'd0:    l.scl = 1'b0;
                    2'd1:    l.sda = 1'b0;
                    2'd2:    l.scl = 1'b1;
                    default: l.sda = 1'b1;
                endcase
            end
            S_WRITE: begin
                if (ph == 2'd0) begin
                    l.scl = 1'b0;
                end else if (ph == 2'd1) begin
                    if (bits < BYTE_BITS) begin
                        l.sda   = shift[7];
                        l.shift = {shift[6:0], 1'b0};
                    end else begin
                        l.sda = 1'b1;
                    end
                end else begin
                    l.scl = 1'b1;
                end
            end
            S_READ: begin
                if (bits < BYTE_BITS) begin
                    if (ph == 2'd0) begin
                        l.scl = 1'b0;
                        l.sda = 1'b1;
                    end else begin
                        l.scl = 1'b1;
                    end
                end else begin
                    case (ph)
                        2'd0:    l.scl = 1'b0;
                        2'd1:    l.sda = !ack;
                        2'd2:    l.scl = 1'b1;
                        default: l.scl = 1'b0;
                    endcase
                end
            end
            S_RPULSE: begin
                l.scl = (ph != 2'd0);
            end
            default: begin
            end
        endcase
        return l;
    endfunction

    t_seq_state r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_bits,  n_bits;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_tick,  n_tick;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;
    logic [1:0] r_status, n_status;
    logic       r_ack,   n_ack;
    logic [7:0] r_hold,  n_hold;

    logic       go_en;
    t_seq_state go_st;
    logic [1:0] go_ph;
    logic       fin_en;
    logic [1:0] fin_st;
    logic       rej;
    logic [7:0] tick_dec;
    t_lines     lines;
    logic       sda_in;

    assign sda_in = i_item.sda_sample;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_tick   = r_tick;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_status = r_status;
        n_ack    = r_ack;
        n_hold   = r_hold;
        go_en    = 1'b0;
        go_st    = r_state;
        go_ph    = r_phase;
        fin_en   = 1'b0;
        fin_st   = STS_OK;
        rej      = 1'b0;
        tick_dec = r_tick;
        lines    = '{scl: r_scl, sda: r_sda, shift: r_shift};

        if (r_state == S_IDLE) begin
            case (i_item.cmd)
                CMD_START: begin
                    go_en = 1'b1;
                    go_st = S_START;
                    go_ph = 2'd0;
                end
                CMD_STOP: begin
                    go_en = 1'b1;
                    go_st = S_STOP;
                    go_ph = 2'd0;
                end
                CMD_WRITE: begin
                    n_shift = i_item.data_byte;
                    n_bits  = '0;
                    go_en   = 1'b1;
                    go_st   = S_WRITE;
                    go_ph   = 2'd0;
                end
                CMD_READ: begin
                    n_shift = '0;
                    n_bits  = '0;
                    n_ack   = i_item.send_ack;
                    go_en   = 1'b1;
                    go_st   = S_READ;
                    go_ph   = 2'd0;
                end
                CMD_RECOVER: begin
                    if (sda_in) begin
                        fin_en = 1'b1;
                        fin_st = STS_OK;
                    end else begin
                        go_en = 1'b1;
                        go_st = S_RPULSE;
                        go_ph = 2'd0;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            rej      = (i_item.cmd != CMD_TICK);
            tick_dec = (r_tick != 8'd0) ? r_tick - 8'd1 : 8'd0;
            n_tick   = tick_dec;
            if (tick_dec == 8'd0) begin
                case (r_state)
                    S_START: begin
                        if (r_phase == 2'd0) begin
                            if (!sda_in) begin
                                fin_en = 1'b1;
                                fin_st = STS_START_FAIL;
                            end else begin
                                go_en = 1'b1;
                                go_st = S_START;
                                go_ph = 2'd1;
                            end
                        end else if (r_phase == 2'd1) begin
                            if (sda_in) begin
                                fin_en = 1'b1;
                                fin_st = STS_START_FAIL;
                            end else begin
                                go_en = 1'b1;
                                go_st = S_START;
                                go_ph = 2'd2;
                            end
                        end else begin
                            fin_en = 1'b1;
                            fin_st = STS_OK;
                        end
                    end
                    S_STOP, S_RSTOP: begin
                        if (r_phase != 2'd3) begin
                            go_en = 1'b1;
                            go_st = r_state;
                            go_ph = r_phase + 2'd1;
                        end else begin
                            fin_en = 1'b1;
                            fin_st = STS_OK;
                        end
                    end
                    S_WRITE: begin
                        if (r_phase < 2'd2) begin
                            go_en = 1'b1;
                            go_st = S_WRITE;
                            go_ph = r_phase + 2'd1;
                        end else if (r_bits < BYTE_BITS) begin
                            n_bits = r_bits + 4'd1;
                            go_en  = 1'b1;
                            go_st  = S_WRITE;
                            go_ph  = 2'd0;
                        end else begin
                            // SCL goes low on the tick the acknowledge is sampled.
                            n_scl  = 1'b0;
                            fin_en = 1'b1;
                            fin_st = sda_in ? STS_NACK : STS_OK;
                        end
                    end
                    S_READ: begin
                        if (r_bits < BYTE_BITS) begin
                            if (r_phase == 2'd0) begin
                                go_en = 1'b1;
                                go_st = S_READ;
                                go_ph = 2'd1;
                            end else begin
                                n_shift = {r_shift[6:0], sda_in};
                                n_bits  = r_bits + 4'd1;
                                go_en   = 1'b1;
                                go_st   = S_READ;
                                go_ph   = 2'd0;
                            end
                        end else if (r_phase != 2'd3) begin
                            go_en = 1'b1;
                            go_st = S_READ;
                            go_ph = r_phase + 2'd1;
                        end else begin
                            n_hold = r_shift;
                            fin_en = 1'b1;
                            fin_st = STS_OK;
                        end
                    end
                    S_RPULSE: begin
                        go_en = 1'b1;
                        if (r_phase == 2'd0) begin
                            go_st = S_RPULSE;
                            go_ph = 2'd1;
                        end else if (sda_in) begin
                            go_st = S_RSTOP;
                            go_ph = 2'd0;
                        end else begin
                            go_st = S_RPULSE;
                            go_ph = 2'd0;
                        end
                    end
                    default: begin
                        fin_en = 1'b1;
                        fin_st = STS_OK;
                    end
                endcase
            end
        end

        if (go_en) begin
            lines   = phase_lines(go_st, go_ph, n_bits, n_shift, n_ack, n_scl, n_sda);
            n_state = go_st;
            n_phase = go_ph;
            n_scl   = lines.scl;
            n_sda   = lines.sda;
            n_shift = lines.shift;
            // A phase length of zero behaves as one tick.
            n_tick  = (i_delay_ticks == 8'd0) ? 8'd1 : i_delay_ticks;
        end
        if (fin_en) begin
            n_state  = S_IDLE;
            n_phase  = 2'd0;
            n_tick   = 8'd0;
            n_status = fin_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 2'd0;
            r_bits   <= '0;
            r_shift  <= '0;
            r_tick   <= '0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_status <= STS_OK;
            r_ack    <= 1'b0;
            r_hold   <= '0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_tick   <= n_tick;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_status <= n_status;
            r_ack    <= n_ack;
            r_hold   <= n_hold;
        end
    end

    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda;
        o_res.busy_res  = (n_state != S_IDLE);
        o_res.done_res  = fin_en;
        o_res.status    = n_status;
        o_res.read_byte = n_hold;
        o_res.rejected  = rej;
    end

endmodule

`default_nettype wire

[dv/i2c_master_bit_sequencer_checker.sv]
// Checker for the I2C master bit sequencer: watches the word channels and the
// configuration port, predicts every result word and compares it field by field.
// Depends on i2cbs_pkg for the codes, the sequence states and the word structs.
`default_nettype none

module i2c_master_bit_sequencer_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [2:0]                  i_cmd,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_send_ack,
    input  wire logic                        i_sda_sample,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_scl_level,
    input  wire logic                        i_sda_level,
    input  wire logic                        i_busy_res,
    input  wire logic                        i_done_res,
    input  wire logic [1:0]                  i_status,
    input  wire logic [7:0]                  i_read_byte,
    input  wire logic                        i_rejected,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cbs_pkg::AddrW-1:0] paddr,
    input  wire logic [i2cbs_pkg::DataW-1:0] pwdata,
    input  wire logic                        pready,
    output int                               o_fail_count,
    output int                               o_pending,
    output bit                               o_seq_busy
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2cbs_pkg::*;

    // Shadow copy of the sequencer state and of the phase length register.
    t_seq_state seq_q;
    logic [2:0] phase_q;
    logic [3:0] bits_q;
    logic [7:0] shift_q;
    logic [7:0] ticks_q;
    logic [7:0] delay_q;
    logic [7:0] read_q;
    logic       scl_q;
    logic       sda_q;
    logic       ack_q;
    logic       done_q;
    logic [1:0] status_q;

    t_result expected_levels[$];
    int      fail_count = 0;

    function automatic void reset_bus_model();
        seq_q    = S_IDLE;
        phase_q  = '0;
        bits_q   = '0;
        shift_q  = '0;
        ticks_q  = '0;
        delay_q  = DELAY_RESET;
        read_q   = '0;
        scl_q    = 1'b1;
        sda_q    = 1'b1;
        ack_q    = 1'b0;
        done_q   = 1'b0;
        status_q = STS_OK;
    endfunction

    // Line levels that a phase drives as it begins.
    function automatic void drive_lines();
        case (seq_q)
            S_START: begin
                if (phase_q == 3'd0) begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end else begin
                    sda_q = 1'b0;
                end
            end
            S_STOP, S_RSTOP: begin
                case (phase_q)
                    3'd0: scl_q = 1'b0;
                    3'd1: sda_q = 1'b0;
                    3'd2: scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            end
            S_WRITE: begin
                if (phase_q == 3'd0) begin
                    scl_q = 1'b0;
                end else if (phase_q == 3'd1) begin
                    if (bits_q < BYTE_BITS) begin
                        sda_q   = shift_q[7];
                        shift_q = {shift_q[6:0], 1'b0};
                    end else begin
                        sda_q = 1'b1;
                    end
                end else begin
                    scl_q = 1'b1;
                end
            end
            S_READ: begin
                if (bits_q < BYTE_BITS) begin
                    if (phase_q == 3'd0) begin
                        scl_q = 1'b0;
                        sda_q = 1'b1;
                    end else begin
                        scl_q = 1'b1;
                    end
                end else begin
                    case (phase_q)
                        3'd0: scl_q = 1'b0;
                        3'd1: sda_q = ~ack_q;
                        3'd2: scl_q = 1'b1;
                        default: scl_q = 1'b0;
                    endcase
                end
            end
            S_RPULSE: scl_q = (phase_q != 3'd0);
            default: ;
        endcase
    endfunction

    function automatic void enter(input t_seq_state st, input logic [2:0] p);
        seq_q   = st;
        phase_q = p;
        drive_lines();
        ticks_q = (delay_q == 8'd0) ? 8'd1 : delay_q;
    endfunction

    function automatic void complete(input logic [1:0] sts);
        seq_q    = S_IDLE;
        phase_q  = '0;
        ticks_q  = '0;
        status_q = sts;
        done_q   = 1'b1;
    endfunction

    // End of a phase: the SDA sample of this tick decides what comes next.
    function automatic void close_phase(input logic sda);
        case (seq_q)
            S_START: begin
                if (phase_q == 3'd0) begin
                    if (!sda) complete(STS_START_FAIL);
                    else enter(S_START, 3'd1);
                end else if (phase_q == 3'd1) begin
                    if (sda) complete(STS_START_FAIL);
                    else enter(S_START, 3'd2);
                end else begin
                    complete(STS_OK);
                end
            end
            S_STOP, S_RSTOP: begin
                if (phase_q < 3'd3) enter(seq_q, phase_q + 3'd1);
                else complete(STS_OK);
            end
            S_WRITE: begin
                if (phase_q < 3'd2) begin
                    enter(S_WRITE, phase_q + 3'd1);
                end else if (bits_q < BYTE_BITS) begin
                    bits_q = bits_q + 4'd1;
                    enter(S_WRITE, 3'd0);
                end else begin
                    // SCL goes low on the tick the acknowledge is sampled.
                    scl_q = 1'b0;
                    complete(sda ? STS_NACK : STS_OK);
                end
            end
            S_READ: begin
                if (bits_q < BYTE_BITS) begin
                    if (phase_q == 3'd0) begin
                        enter(S_READ, 3'd1);
                    end else begin
                        shift_q = {shift_q[6:0], sda};
                        bits_q  = bits_q + 4'd1;
                        enter(S_READ, 3'd0);
                    end
                end else if (phase_q < 3'd3) begin
                    enter(S_READ, phase_q + 3'd1);
                end else begin
                    read_q = shift_q;
                    complete(STS_OK);
                end
            end
            S_RPULSE: begin
                if (phase_q == 3'd0) enter(S_RPULSE, 3'd1);
                else if (sda) enter(S_RSTOP, 3'd0);
                else enter(S_RPULSE, 3'd0);
            end
            default: complete(STS_OK);
        endcase
    endfunction

    // One bus tick: advance the shadow sequencer and return the levels it shows.
    function automatic t_result predict_bus_word(input t_item w);
        t_result r;
        logic    rej;
        rej    = 1'b0;
        done_q = 1'b0;
        if (seq_q == S_IDLE) begin
            case (w.cmd)
                CMD_START: enter(S_START, 3'd0);
                CMD_STOP:  enter(S_STOP, 3'd0);
                CMD_WRITE: begin
                    shift_q = w.data_byte;
                    bits_q  = '0;
                    enter(S_WRITE, 3'd0);
                end
                CMD_READ: begin
                    shift_q = '0;
                    bits_q  = '0;
                    ack_q   = w.send_ack;
                    enter(S_READ, 3'd0);
                end
                CMD_RECOVER: begin
                    if (w.sda_sample) complete(STS_OK);
                    else enter(S_RPULSE, 3'd0);
                end
                default: ;
            endcase
        end else begin
            if (w.cmd != CMD_TICK) rej = 1'b1;
            if (ticks_q != 8'd0) ticks_q = ticks_q - 8'd1;
            if (ticks_q == 8'd0) close_phase(w.sda_sample);
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = (seq_q != S_IDLE);
        r.done_res  = done_q;
        r.status    = status_q;
        r.read_byte = read_q;
        r.rejected  = rej;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        t_item   word;
        if (!i_rst_n) begin
            reset_bus_model();
            expected_levels.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[AddrW-1:2] == REG_DELAY)
                delay_q = pwdata[7:0];
            if (i_out_valid && i_out_ready) begin
                seen.scl_level = i_scl_level;
                seen.sda_level = i_sda_level;
                seen.busy_res  = i_busy_res;
                seen.done_res  = i_done_res;
                seen.status    = i_status;
                seen.read_byte = i_read_byte;
                seen.rejected  = i_rejected;
                if (expected_levels.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    fail_count++;
                end else begin
                    want = expected_levels.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(seen.scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(seen.sda_level));
                    check_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(seen.done_res));
                    check_field("status", 8'(want.status), 8'(seen.status));
                    check_field("read_byte", want.read_byte, seen.read_byte);
                    check_field("rejected", 8'(want.rejected), 8'(seen.rejected));
                end
            end
            if (i_in_valid && i_in_ready) begin
                word.cmd        = i_cmd;
                word.data_byte  = i_data_byte;
                word.send_ack   = i_send_ack;
                word.sda_sample = i_sda_sample;
                expected_levels.push_back(predict_bus_word(word));
            end
        end
        o_pending    <= expected_levels.size();
        o_seq_busy   <= (seq_q != S_IDLE);
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

[dv/i2c_master_bit_sequencer_top_tb.sv]
// Testbench top for the I2C master bit sequencer: clock, reset, word and
// configuration stimulus, and the final verdict.
// Depends on i2cbs_pkg, the block and i2c_master_bit_sequencer_checker.
`default_nettype none

module i2c_master_bit_sequencer_top_tb;
    import i2cbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block does not define; while idle they must act as plain ticks.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    // Length of the one long receiver hold-off, in clock cycles.
    localparam int HoldOffCycles = 400;

    // Minimum number of words sent per random phase.
    localparam int PhaseWords = 200;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    logic [2:0]       i_cmd        = CMD_TICK;
    logic [7:0]       i_data_byte  = '0;
    logic             i_send_ack   = 1'b0;
    logic             i_sda_sample = 1'b1;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    logic             o_scl_level;
    logic             o_sda_level;
    logic             o_busy_res;
    logic             o_done_res;
    logic [1:0]       o_status;
    logic [7:0]       o_read_byte;
    logic             o_rejected;
    logic             psel         = 1'b0;
    logic             penable      = 1'b0;
    logic             pwrite       = 1'b0;
    logic [AddrW-1:0] paddr        = '0;
    logic [DataW-1:0] pwdata       = '0;
    logic [DataW-1:0] prdata;
    logic             pready;

    int fail_count;
    int pending_words;
    bit seq_busy;

    // Stimulus controls; quiet and stall_req are shared between the sender and the receiver.
    bit         quiet      = 1'b0;  // no idling on either side while set
    bit         stall_req  = 1'b0;  // asks the receiver for its long hold-off
    int         words_sent = 0;
    logic [7:0] delay_now  = DELAY_RESET;

    i2c_master_bit_sequencer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_sample (i_sda_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .o_read_byte  (o_read_byte),
        .o_rejected   (o_rejected),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    i2c_master_bit_sequencer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_send_ack   (i_send_ack),
        .i_sda_sample (i_sda_sample),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_scl_level  (o_scl_level),
        .i_sda_level  (o_sda_level),
        .i_busy_res   (o_busy_res),
        .i_done_res   (o_done_res),
        .i_status     (o_status),
        .i_read_byte  (o_read_byte),
        .i_rejected   (o_rejected),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_seq_busy   (seq_busy)
    );

    // 50 MHz clock, starting low so that the first rising edge is at 10 ns.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver. It drops ready at random about 16 percent of the time, except in the
    // quiet phase. When asked, it holds ready low for a long stretch while the
    // sender keeps offering words, so both of the block's registers fill up
    // and its input ready has to fall.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                i_out_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                stall_req = 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    // Offers one word and returns at the edge where it is accepted. Valid is
    // left high, so the caller must either offer the next word in the same
    // time step or park the channel.
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] data,
                             input logic ack, input logic sda);
        while (!quiet && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_data_byte  <= data;
        i_send_ack   <= ack;
        i_sda_sample <= sda;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic park_input();
        i_in_valid <= 1'b0;
    endtask

    // Brings the block to rest before a register write: every result word has
    // been taken and the sequencer is idle. A sequence left running by noise is
    // clocked out with ticks that see SDA released, which also ends a recovery.
    task automatic settle();
        bit at_rest;
        at_rest = 1'b0;
        park_input();
        while (!at_rest) begin
            do @(posedge i_clk); while (pending_words != 0);
            if (seq_busy) begin
                send_word(CMD_TICK, 8'($urandom), 1'($urandom), 1'b1);
                park_input();
            end else begin
                at_rest = 1'b1;
            end
        end
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the phase length: setup cycle, then access cycle. The
    // upper data bits are random; only the low byte is meaningful.
    task automatic program_delay(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(REG_DELAY) << 2;
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        delay_now = value;
    endtask

    // Issues one command word followed by the ticks it should take to finish,
    // plus slack (negative slack makes the next command land while busy).
    // The SDA samples play the part of a cooperating slave: a free bus for a
    // start, an acknowledge for a write, and for recovery a line held low for
    // a few clock pulses and then released. A nonzero fault makes the bus
    // misbehave: a start sees SDA low too early (1) or never low (2), a write
    // sees no acknowledge, and a recovery finds SDA already high. Noisy runs
    // flip some samples. In any run, a few ticks inside the sequence carry
    // stray commands, which the block rejects while it is busy.
    task automatic run_command(input logic [2:0] cmd, input logic [7:0] data,
                               input logic ack, input int fault, input bit noisy,
                               input int slack);
        int         d;
        int         len;
        int         pulses;
        int         t;
        logic       sda;
        logic [2:0] stray;
        d      = (delay_now == 8'd0) ? 1 : int'(delay_now);
        pulses = $urandom_range(3);
        case (cmd)
            CMD_START:   len = 3 * d;
            CMD_STOP:    len = 4 * d;
            CMD_WRITE:   len = 27 * d;
            CMD_READ:    len = 20 * d;
            CMD_RECOVER: len = (fault != 0) ? 0 : (pulses + 3) * 2 * d;
            default:     len = 0;
        endcase
        for (t = 0; t <= len + slack; t++) begin
            case (cmd)
                CMD_START: begin
                    if (fault == 1) sda = 1'b0;
                    else if (fault == 2) sda = 1'b1;
                    else sda = (t <= d);
                end
                CMD_WRITE:   sda = (t == len) ? (fault != 0) : 1'($urandom);
                CMD_RECOVER: sda = (fault != 0) ? 1'b1 : (t > 2 * d * pulses);
                default:     sda = 1'($urandom);
            endcase
            if (noisy && $urandom_range(7) == 0) sda = ~sda;
            stray = CMD_TICK;
            if (t > 0 && t < len && $urandom_range(15) == 0) stray = 3'($urandom_range(7, 1));
            if (t == 0) send_word(cmd, data, ack, sda);
            else send_word(stray, 8'($urandom), 1'($urandom), sda);
        end
    endtask

    initial begin
        logic [7:0] phase_delays[5];
        logic [2:0] cmd;
        int         fault;
        int         slack;
        int         ph;
        int         phase_start;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first start runs at the reset phase length.
        run_command(CMD_START, 8'($urandom), 1'($urandom), 0, 1'b0, 0);
        settle();
        program_delay(8'd1);
        run_command(CMD_START, 8'($urandom), 1'($urandom), 1, 1'b0, 1);
        run_command(CMD_START, 8'($urandom), 1'($urandom), 2, 1'b0, 1);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 0, 1'b0, 0);
        run_command(CMD_WRITE, 8'h00, 1'b1, 1, 1'b0, 0);
        run_command(CMD_WRITE, 8'hA5, 1'b0, 0, 1'b0, 1);
        run_command(CMD_READ, 8'($urandom), 1'b1, 0, 1'b0, 0);
        run_command(CMD_READ, 8'($urandom), 1'b0, 0, 1'b0, 0);
        run_command(CMD_STOP, 8'($urandom), 1'($urandom), 0, 1'b0, 0);
        // Recovery on a free bus finishes at once; on a stuck bus it pulses.
        run_command(CMD_RECOVER, 8'($urandom), 1'($urandom), 1, 1'b0, 0);
        run_command(CMD_RECOVER, 8'($urandom), 1'($urandom), 0, 1'b0, 0);
        // A read issued while the write is still running must be rejected.
        run_command(CMD_WRITE, 8'h5A, 1'b0, 0, 1'b0, -4);
        run_command(CMD_READ, 8'($urandom), 1'b1, 0, 1'b0, 0);
        run_command(CMD_SPARE_A, 8'($urandom), 1'($urandom), 0, 1'b0, 0);
        run_command(CMD_SPARE_B, 8'($urandom), 1'($urandom), 0, 1'b0, 0);
        // A phase length of zero behaves as one, the largest one is 255 ticks.
        settle();
        program_delay(8'd0);
        run_command(CMD_START, 8'($urandom), 1'($urandom), 0, 1'b0, 0);
        settle();
        program_delay(8'd255);
        run_command(CMD_START, 8'($urandom), 1'($urandom), 0, 1'b0, 0);

        // Random part: five phases, each at its own short phase length so that
        // many complete sequences fit. Phase 1 runs with no idling at all and
        // phase 2 opens with the long receiver hold-off.
        phase_delays[0] = 8'd1;
        phase_delays[1] = 8'd2;
        phase_delays[2] = 8'd3;
        phase_delays[3] = 8'd0;
        phase_delays[4] = 8'($urandom_range(6, 1));
        for (ph = 0; ph < 5; ph++) begin
            settle();
            program_delay(phase_delays[ph]);
            quiet = (ph == 1);
            if (ph == 2) stall_req = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < PhaseWords) begin
                if ($urandom_range(9) == 0) begin
                    // A burst of words with every field random.
                    repeat ($urandom_range(16, 4))
                        send_word(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                end else begin
                    cmd   = 3'($urandom_range(int'(CMD_RECOVER), int'(CMD_START)));
                    fault = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : 0;
                    slack = ($urandom_range(9) == 0) ? -1 : $urandom_range(3);
                    run_command(cmd, 8'($urandom), 1'($urandom), fault,
                                $urandom_range(7) == 0, slack);
                end
            end
        end
        quiet = 1'b0;

        // Drain: every word has one result, then allow a few more cycles so a
        // stray extra result word would still be caught.
        park_input();
        do @(posedge i_clk); while (pending_words != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
